[rtl/ctc_pkg.sv]
// ---------------------------------------------------------------------------
// ctc_pkg: shared definitions for the color threshold centroid block
// Frame geometry, field widths, register indexes, reset values, FSM states.
// ---------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

    localparam int FRAME_WIDTH  = 480;
    localparam int FRAME_HEIGHT = 272;

    localparam int COL_W = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
    localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 26;
    localparam int CNT_W   = 17;
    localparam int COORD_W = 9;
    localparam int CFG_IDX_W = 2;

    // one quotient bit per step over the whole dividend
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_RED_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MAX  = 2'd2;

    localparam logic [PIX_W-1:0] RED_MIN_RESET   = 8'd190;
    localparam logic [PIX_W-1:0] GREEN_MAX_RESET = 8'd60;
    localparam logic [PIX_W-1:0] BLUE_MAX_RESET  = 8'd60;

    localparam logic [COORD_W-1:0] HELD_X_RESET = 9'd240;
    localparam logic [COORD_W-1:0] HELD_Y_RESET = 9'd137;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[rtl/color_threshold_centroid.sv]
// ---------------------------------------------------------------------------
// color_threshold_centroid: color blob centroid tracker
// Thresholds raster pixels, accumulates matching coordinates and divides the
// sums by the match count once per frame with a shared restoring divider.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  pix      in   pix_valid/pix_ready    red, green, blue, last_pixel
//  res      out  res_valid/res_ready    centroid_x, centroid_y, match_total,
//                                       target_found
//  cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  Ordinary pixel: accepted in IDLE, pix_ready stays high.
//  Last pixel with matches: DIV_X, DIV_Y, then EMIT; the single restoring
//  divide step (one quotient bit a cycle) runs for x, then for y.
//  Last pixel without matches: to EMIT. EMIT waits while a result is held.
//  Reset restores thresholds, clears counters, sets the held centroid.
//  cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module color_threshold_centroid (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            pix_valid,
    output logic                                 pix_ready,
    input  wire logic [ctc_pkg::PIX_W-1:0]       red,
    input  wire logic [ctc_pkg::PIX_W-1:0]       green,
    input  wire logic [ctc_pkg::PIX_W-1:0]       blue,
    input  wire logic                            last_pixel,

    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output logic [ctc_pkg::COORD_W-1:0]          centroid_x,
    output logic [ctc_pkg::COORD_W-1:0]          centroid_y,
    output logic [ctc_pkg::CNT_W-1:0]            match_total,
    output logic                                 target_found,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ctc_pkg::PIX_W-1:0]       cfg_data
);

    localparam int COL_W   = ctc_pkg::COL_W;
    localparam int ROW_W   = ctc_pkg::ROW_W;
    localparam int SUM_W   = ctc_pkg::SUM_W;
    localparam int CNT_W   = ctc_pkg::CNT_W;
    localparam int COORD_W = ctc_pkg::COORD_W;
    localparam int STEP_W  = ctc_pkg::STEP_W;

    ctc_pkg::state_t state_reg, state_next;

    logic [ctc_pkg::PIX_W-1:0] red_min_reg, green_max_reg, blue_max_reg;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [SUM_W-1:0]   csum_reg, csum_next;
    logic [SUM_W-1:0]   rsum_reg, rsum_next;
    logic [CNT_W-1:0]   mcount_reg, mcount_next;

    // divider operands and working state
    logic [SUM_W-1:0]   num_reg, num_next;
    logic [SUM_W-1:0]   rsum_hold_reg, rsum_hold_next;
    logic [CNT_W-1:0]   divisor_reg, divisor_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0] quo_reg, quo_next;
    logic [COORD_W-1:0] qx_reg, qx_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               found_pend_reg, found_pend_next;
    logic [CNT_W-1:0]   total_pend_reg, total_pend_next;

    logic [COORD_W-1:0] held_x_reg, held_x_next;
    logic [COORD_W-1:0] held_y_reg, held_y_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic               found_reg, found_next;
    logic               res_valid_reg, res_valid_next;

    logic               pix_fire;
    logic               div_step;
    logic               emit_load;
    logic               step_last;

    logic               hit;
    logic               room;
    logic [SUM_W:0]     csum_add, rsum_add;
    logic [SUM_W-1:0]   csum_upd, rsum_upd;
    logic [CNT_W-1:0]   mcount_upd;

    logic [CNT_W:0]     rem_shift;
    logic [CNT_W:0]     rem_diff;
    logic               rem_ge;

    assign cfg_ready    = 1'b1;
    assign res_valid    = res_valid_reg;
    assign centroid_x   = held_x_reg;
    assign centroid_y   = held_y_reg;
    assign match_total  = total_reg;
    assign target_found = found_reg;

    assign pix_fire  = pix_valid && pix_ready;
    assign step_last = (step_reg == STEP_W'(ctc_pkg::DIV_STEPS - 1));

    // pixel test and guarded accumulation
    always_comb
    begin
        hit = (red > red_min_reg) && (green < green_max_reg) && (blue < blue_max_reg);
        csum_add = {1'b0, csum_reg} + (SUM_W+1)'(col_reg);
        rsum_add = {1'b0, rsum_reg} + (SUM_W+1)'(row_reg);
        room = (mcount_reg < ctc_pkg::COUNT_MAX)
            && (csum_add <= {1'b0, ctc_pkg::SUM_MAX})
            && (rsum_add <= {1'b0, ctc_pkg::SUM_MAX});
        if (hit && room)
        begin
            csum_upd   = csum_add[SUM_W-1:0];
            rsum_upd   = rsum_add[SUM_W-1:0];
            mcount_upd = mcount_reg + CNT_W'(1);
        end
        else
        begin
            csum_upd   = csum_reg;
            rsum_upd   = rsum_reg;
            mcount_upd = mcount_reg;
        end
    end

    // shared restoring divide step
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctc_pkg::ST_IDLE:
            begin
                if (pix_fire && last_pixel)
                begin
                    if (mcount_upd != '0)
                        state_next = ctc_pkg::ST_DIV_X;
                    else
                        state_next = ctc_pkg::ST_EMIT;
                end
            end
            ctc_pkg::ST_DIV_X:
            begin
                if (step_last)
                    state_next = ctc_pkg::ST_DIV_Y;
            end
            ctc_pkg::ST_DIV_Y:
            begin
                if (step_last)
                    state_next = ctc_pkg::ST_EMIT;
            end
            ctc_pkg::ST_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                    state_next = ctc_pkg::ST_IDLE;
            end
            default:
                state_next = ctc_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        pix_ready = 1'b0;
        div_step  = 1'b0;
        emit_load = 1'b0;
        case (state_reg)
            ctc_pkg::ST_IDLE:  pix_ready = 1'b1;
            ctc_pkg::ST_DIV_X: div_step  = 1'b1;
            ctc_pkg::ST_DIV_Y: div_step  = 1'b1;
            ctc_pkg::ST_EMIT:  emit_load = !res_valid_reg || res_ready;
            default:
            begin
                pix_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        csum_next       = csum_reg;
        rsum_next       = rsum_reg;
        mcount_next     = mcount_reg;
        num_next        = num_reg;
        rsum_hold_next  = rsum_hold_reg;
        divisor_next    = divisor_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        qx_next         = qx_reg;
        step_next       = step_reg;
        found_pend_next = found_pend_reg;
        total_pend_next = total_pend_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        total_next      = total_reg;
        found_next      = found_reg;
        res_valid_next  = res_valid_reg;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        if (pix_fire)
        begin
            if (last_pixel)
            begin
                // hand the frame totals to the divider, restart the frame
                num_next        = csum_upd;
                rsum_hold_next  = rsum_upd;
                divisor_next    = mcount_upd;
                found_pend_next = (mcount_upd != '0);
                total_pend_next = mcount_upd;
                rem_next        = '0;
                quo_next        = '0;
                step_next       = '0;
                col_next        = '0;
                row_next        = '0;
                csum_next       = '0;
                rsum_next       = '0;
                mcount_next     = '0;
            end
            else
            begin
                csum_next   = csum_upd;
                rsum_next   = rsum_upd;
                mcount_next = mcount_upd;
                if (col_reg == COL_W'(ctc_pkg::FRAME_WIDTH - 1))
                begin
                    col_next = '0;
                    if (row_reg == ROW_W'(ctc_pkg::FRAME_HEIGHT - 1))
                        row_next = '0;
                    else
                        row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end

        if (div_step)
        begin
            num_next  = {num_reg[SUM_W-2:0], 1'b0};
            rem_next  = rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            quo_next  = {quo_reg[COORD_W-2:0], rem_ge};
            step_next = step_reg + STEP_W'(1);
            if (step_last && (state_reg == ctc_pkg::ST_DIV_X))
            begin
                qx_next   = {quo_reg[COORD_W-2:0], rem_ge};
                num_next  = rsum_hold_reg;
                rem_next  = '0;
                quo_next  = '0;
                step_next = '0;
            end
        end

        if (emit_load)
        begin
            if (found_pend_reg)
            begin
                held_x_next = qx_reg;
                held_y_next = quo_reg;
            end
            total_next     = total_pend_reg;
            found_next     = found_pend_reg;
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctc_pkg::ST_IDLE;
            red_min_reg   <= ctc_pkg::RED_MIN_RESET;
            green_max_reg <= ctc_pkg::GREEN_MAX_RESET;
            blue_max_reg  <= ctc_pkg::BLUE_MAX_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            csum_reg      <= '0;
            rsum_reg      <= '0;
            mcount_reg    <= '0;
            step_reg      <= '0;
            held_x_reg    <= ctc_pkg::HELD_X_RESET;
            held_y_reg    <= ctc_pkg::HELD_Y_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            csum_reg      <= csum_next;
            rsum_reg      <= rsum_next;
            mcount_reg    <= mcount_next;
            step_reg      <= step_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ctc_pkg::CFG_RED_MIN:   red_min_reg   <= cfg_data;
                    ctc_pkg::CFG_GREEN_MAX: green_max_reg <= cfg_data;
                    ctc_pkg::CFG_BLUE_MAX:  blue_max_reg  <= cfg_data;
                    default:
                    begin
                        red_min_reg <= red_min_reg;
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        num_reg        <= num_next;
        rsum_hold_reg  <= rsum_hold_next;
        divisor_reg    <= divisor_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        qx_reg         <= qx_next;
        found_pend_reg <= found_pend_next;
        total_pend_reg <= total_pend_next;
        total_reg      <= total_next;
        found_reg      <= found_next;
    end

`ifndef NO_ASSERTIONS
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_fire && last_pixel) |=> !pix_ready)
        else $error("pixel accepted right after last pixel");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        div_step |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_step |-> (divisor_reg != '0))
        else $error("divide by zero count");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && target_found) |-> (match_total != '0))
        else $error("target found with zero matches");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(ctc_pkg::FRAME_WIDTH - 1))
        else $error("column counter out of range");
`endif

endmodule

`default_nettype wire
